FILE: rtl/estp_pkg.sv
package estp_pkg;

    localparam logic [1:0] OP_PARSE = 2'd0;
    localparam logic [1:0] OP_WR_ENTRY = 2'd1;
    localparam logic [1:0] OP_WR_STATE = 2'd2;
    localparam logic [1:0] OP_READ = 2'd3;

    localparam logic [5:0] ACT_NONE = 6'd0;
    localparam logic [5:0] ACT_CLEAR = 6'd1;
    localparam logic [5:0] ACT_DIGIT = 6'd2;
    localparam logic [5:0] ACT_SIGN = 6'd3;
    localparam logic [5:0] ACT_PUSH_FIRST = 6'd4;
    localparam logic [5:0] ACT_PUSH_LAST = 6'd19;

    localparam logic [30:0] DIGIT_LIMIT = 31'h07FF_FFFF;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_MINUS = 8'h2d;
    localparam logic [1:0] SIGN_NONE = 2'd0;
    localparam logic [1:0] SIGN_POS = 2'd1;
    localparam logic [1:0] SIGN_NEG = 2'd2;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] char_byte;
        logic       is_multibyte;
        logic [7:0] table_index;
        logic [7:0] range_lower;
        logic [7:0] range_upper;
        logic [5:0] target_state;
        logic [5:0] action_code;
        logic       keep_state;
        logic [7:0] pre_base;
        logic [7:0] main_base;
        logic [1:0] state_flags;
    } item_t;

    typedef struct packed {
        logic       not_at_start;
        logic [5:0] action_out;
        logic       action_taken;
        logic       matched_pre;
        logic       no_match;
        logic [30:0] working_number;
        logic       number_is_default;
        logic [1:0] sign_code;
        logic [30:0] read_value;
    } result_t;

    // Controller to datapath.
    typedef struct packed {
        logic load;       // capture item
        logic wr_entry;
        logic wr_state;
        logic rd_desc;    // read current state descriptor
        logic desc_ready; // descriptor data valid, set up walk
        logic start_main; // begin main walk
        logic rd_entry;   // read entry at walk pointer
        logic step;       // evaluate returned entry, advance pointer
        logic finish;     // apply result
        logic rd_flags;   // read flags of new state
        logic emit;       // build result word
    } cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic is_parse;
        logic pre_enabled;
        logic hit;
        logic walk_end;
        logic in_pre;
    } status_t;

endpackage

FILE: rtl/estp_ram.sv
module estp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/estp_ctrl.sv
module estp_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_fire,
    input  logic              out_busy,
    input  estp_pkg::status_t sts,
    output logic              idle,
    output estp_pkg::cmd_t    cmd
);

    import estp_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DECODE = 4'd1;
    localparam logic [3:0] S_DESC = 4'd2;
    localparam logic [3:0] S_SETUP = 4'd3;
    localparam logic [3:0] S_REQ = 4'd4;
    localparam logic [3:0] S_EVAL = 4'd5;
    localparam logic [3:0] S_APPLY = 4'd6;
    localparam logic [3:0] S_FLAGS = 4'd7;
    localparam logic [3:0] S_FLAGW = 4'd8;
    localparam logic [3:0] S_EMIT = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd = '0;
        state_next = state_reg;
        idle = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                idle = 1'b1;
                if (in_fire)
                begin
                    cmd.load = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (sts.is_parse)
                begin
                    cmd.rd_desc = 1'b1;
                    state_next = S_DESC;
                end
                else
                begin
                    cmd.wr_entry = 1'b1;
                    cmd.wr_state = 1'b1;
                    cmd.rd_flags = 1'b1;
                    state_next = S_FLAGW;
                end
            end
            S_DESC:
            begin
                state_next = S_SETUP;
            end
            S_SETUP:
            begin
                cmd.desc_ready = 1'b1;
                state_next = S_REQ;
            end
            S_REQ:
            begin
                cmd.rd_entry = 1'b1;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                cmd.step = 1'b1;
                if (sts.hit)
                begin
                    state_next = S_APPLY;
                end
                else if (sts.walk_end)
                begin
                    if (sts.in_pre)
                    begin
                        cmd.start_main = 1'b1;
                        state_next = S_REQ;
                    end
                    else
                    begin
                        state_next = S_APPLY;
                    end
                end
                else
                begin
                    state_next = S_REQ;
                end
            end
            S_APPLY:
            begin
                cmd.finish = 1'b1;
                state_next = S_FLAGS;
            end
            S_FLAGS:
            begin
                cmd.rd_flags = 1'b1;
                state_next = S_FLAGW;
            end
            S_FLAGW:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!out_busy)
                begin
                    cmd.emit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/estp_datapath.sv
module estp_datapath #(
    parameter int ENTRIES = 256,
    parameter int STATES = 64,
    parameter int NUM_PARAMS = 16,
    parameter int MAX_WALK = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  estp_pkg::item_t   item,
    input  estp_pkg::cmd_t    cmd,
    output estp_pkg::status_t sts,
    output estp_pkg::result_t res
);

    import estp_pkg::*;

    localparam int EW = $clog2(ENTRIES);
    localparam int SW = $clog2(STATES);
    localparam int PW = (NUM_PARAMS > 1) ? $clog2(NUM_PARAMS) : 1;
    localparam int CW = $clog2(MAX_WALK + 1);

    item_t        it_reg;
    logic [5:0]   cur_reg, cur_next;
    logic [30:0]  acc_reg, acc_next;
    logic         dflt_reg, dflt_next;
    logic [1:0]   sign_reg, sign_next;
    logic [30:0]  slot_reg [NUM_PARAMS];
    logic [EW-1:0] ptr_reg;
    logic [7:0]   mbase_reg;
    logic [CW-1:0] cnt_reg;
    logic         in_pre_reg, hit_reg, pre_hit_reg, miss_reg;
    logic [5:0]   act_reg;
    logic [5:0]   hit_target_reg;
    logic         hit_keep_reg;
    logic [30:0]  readv_reg;

    logic [7:0]   e_lo, e_hi;
    logic [5:0]   e_tg, e_ac;
    logic         e_kp;
    logic [7:0]   d_pre, d_main;
    logic [1:0]   d_bits;
    logic [SW-1:0] s_raddr;
    logic         s_raddr_ok_reg;

    logic e_we, s_we;
    logic [EW-1:0] e_waddr;
    logic [SW-1:0] s_waddr;

    assign e_we = cmd.wr_entry && it_reg.opcode == OP_WR_ENTRY
                  && {2'b0, it_reg.table_index} < 10'(ENTRIES);
    assign s_we = cmd.wr_state && it_reg.opcode == OP_WR_STATE
                  && {1'b0, it_reg.table_index} < 9'(STATES);
    assign e_waddr = EW'(it_reg.table_index);
    assign s_waddr = SW'(it_reg.table_index);
    assign s_raddr = SW'(cur_reg);

    estp_ram #(.WIDTH(29), .DEPTH(ENTRIES)) u_entries (
        .clk(clk), .we(e_we), .waddr(e_waddr),
        .wdata({it_reg.range_lower, it_reg.range_upper, it_reg.target_state,
                it_reg.action_code, it_reg.keep_state}),
        .raddr(ptr_reg), .rdata({e_lo, e_hi, e_tg, e_ac, e_kp})
    );

    estp_ram #(.WIDTH(18), .DEPTH(STATES)) u_states (
        .clk(clk), .we(s_we), .waddr(s_waddr),
        .wdata({it_reg.pre_base, it_reg.main_base, it_reg.state_flags}),
        .raddr(s_raddr), .rdata({d_pre, d_main, d_bits})
    );

    logic [1:0] flags_eff;
    assign flags_eff = s_raddr_ok_reg ? d_bits : 2'b00;

    logic full_rng, in_rng, match;
    assign full_rng = e_lo == 8'h00 && e_hi == 8'hff;
    assign in_rng = it_reg.char_byte >= e_lo && it_reg.char_byte <= e_hi;
    assign match = in_pre_reg ? (in_rng && !full_rng)
                 : (it_reg.is_multibyte ? full_rng : in_rng);

    assign sts.is_parse = it_reg.opcode == OP_PARSE;
    assign sts.pre_enabled = flags_eff[0] && !it_reg.is_multibyte;
    assign sts.hit = match;
    assign sts.walk_end = (in_pre_reg && in_rng && full_rng)
                          || cnt_reg == CW'(MAX_WALK - 1);
    assign sts.in_pre = in_pre_reg;

    logic [34:0] digit_val;
    assign digit_val = {acc_reg, 3'b0} + {2'b0, acc_reg, 1'b0}
                       + 35'(it_reg.char_byte) - 35'(CHAR_ZERO);

    logic [5:0] slot_code;
    assign slot_code = act_reg - ACT_PUSH_FIRST;

    always_comb
    begin
        cur_next = cur_reg;
        acc_next = acc_reg;
        dflt_next = dflt_reg;
        sign_next = sign_reg;
        if (cmd.finish && hit_reg)
        begin
            if (!(pre_hit_reg && hit_keep_reg))
            begin
                cur_next = hit_target_reg;
            end
            priority if (act_reg == ACT_CLEAR)
            begin
                acc_next = '0;
                dflt_next = 1'b1;
                sign_next = SIGN_NONE;
            end
            else if (act_reg == ACT_DIGIT)
            begin
                if (acc_reg < DIGIT_LIMIT)
                begin
                    acc_next = digit_val[30:0];
                end
                dflt_next = 1'b0;
            end
            else if (act_reg == ACT_SIGN)
            begin
                sign_next = (it_reg.char_byte == CHAR_MINUS) ? SIGN_NEG : SIGN_POS;
            end
            else if (act_reg >= ACT_PUSH_FIRST && act_reg <= ACT_PUSH_LAST
                     && {1'b0, slot_code} < 7'(NUM_PARAMS))
            begin
                acc_next = '0;
                dflt_next = 1'b0;
            end
            else
            begin
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg <= '0;
            acc_reg <= '0;
            dflt_reg <= 1'b1;
            sign_reg <= SIGN_NONE;
            for (int i = 0; i < NUM_PARAMS; i++)
            begin
                slot_reg[i] <= '0;
            end
        end
        else
        begin
            cur_reg <= cur_next;
            acc_reg <= acc_next;
            dflt_reg <= dflt_next;
            sign_reg <= sign_next;
            if (cmd.finish && hit_reg)
            begin
                for (int i = 0; i < NUM_PARAMS; i++)
                begin
                    if (act_reg == ACT_CLEAR
                        || (act_reg >= ACT_PUSH_FIRST && act_reg <= ACT_PUSH_LAST
                            && {1'b0, slot_code} == 7'(i)))
                    begin
                        slot_reg[i] <= (act_reg == ACT_CLEAR) ? '0 : acc_reg;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            it_reg <= item;
        end
        if (cmd.rd_desc || cmd.rd_flags)
        begin
            s_raddr_ok_reg <= {3'b0, cur_next} < 9'(STATES);
        end
        if (cmd.rd_desc)
        begin
            hit_reg <= 1'b0;
            pre_hit_reg <= 1'b0;
            miss_reg <= 1'b0;
            act_reg <= ACT_NONE;
            readv_reg <= '0;
        end
        if (cmd.wr_entry)
        begin
            hit_reg <= 1'b0;
            pre_hit_reg <= 1'b0;
            miss_reg <= 1'b0;
            act_reg <= ACT_NONE;
            readv_reg <= (it_reg.opcode == OP_READ
                          && {1'b0, it_reg.table_index} < 9'(NUM_PARAMS))
                         ? slot_reg[PW'(it_reg.table_index)] : '0;
        end
        if (cmd.desc_ready)
        begin
            in_pre_reg <= sts.pre_enabled;
            ptr_reg <= EW'(sts.pre_enabled ? (s_raddr_ok_reg ? d_pre : 8'h00)
                                          : (s_raddr_ok_reg ? d_main : 8'h00));
            mbase_reg <= s_raddr_ok_reg ? d_main : 8'h00;
            cnt_reg <= '0;
        end
        if (cmd.step)
        begin
            if (match)
            begin
                hit_reg <= 1'b1;
                pre_hit_reg <= in_pre_reg;
                act_reg <= e_ac;
                hit_target_reg <= e_tg;
                hit_keep_reg <= e_kp;
            end
            else if (cmd.start_main)
            begin
                in_pre_reg <= 1'b0;
                ptr_reg <= EW'(mbase_reg);
                cnt_reg <= '0;
            end
            else if (sts.walk_end)
            begin
                miss_reg <= 1'b1;
            end
            else
            begin
                ptr_reg <= (ptr_reg == EW'(ENTRIES - 1)) ? '0 : ptr_reg + 1'b1;
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
        if (cmd.emit)
        begin
            res.not_at_start <= !flags_eff[1];
            res.action_out <= hit_reg ? act_reg : ACT_NONE;
            res.action_taken <= hit_reg && act_reg != ACT_NONE;
            res.matched_pre <= hit_reg && pre_hit_reg;
            res.no_match <= miss_reg;
            res.working_number <= acc_reg;
            res.number_is_default <= dflt_reg;
            res.sign_code <= sign_reg;
            res.read_value <= readv_reg;
        end
    end

endmodule

FILE: rtl/escape_sequence_table_parser_unit.sv
// Table-driven escape sequence parser.
// One input stream (s_axis) carries load, read and parse words; every word
// gives exactly one result word on the output stream (m_axis).
// Opcode 1 writes a range entry, 2 writes a state descriptor, 3 reads a
// parameter slot and 0 parses one character byte.
// A write or read is decoded, reads the flags of the current state and then
// builds its result word. A parse reads the state descriptor, walks the range
// entries of the pre-parse and main lists, applies the result and reads the
// new state's flags; each entry visited is one entry memory read and one compare.
// Only one word is in flight: s_axis_tready is high while the block is idle
// and no result word waits; the next word can be accepted in the cycle after
// the result word is taken.
// The result is held in an output register until taken; while the receiver
// stalls no new word is accepted.
// Reset returns the parser to state zero, clears the number, sign and
// parameter slots, and empties the output register. The entry and descriptor
// memories are not cleared and must be loaded before use.
module escape_sequence_table_parser_unit #(
    parameter int ENTRIES = 256,
    parameter int STATES = 64,
    parameter int NUM_PARAMS = 16,
    parameter int MAX_WALK = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // opcode, char_byte, is_multibyte, table_index, range_lower, range_upper,
    // target_state, action_code, keep_state, pre_base, main_base,
    // state_flags, then zero fill.
    input  logic [71:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // not_at_start, action_out, action_taken, matched_pre, no_match,
    // working_number, number_is_default, sign_code, read_value, zero fill.
    output logic [79:0]  m_axis_tdata
);

    import estp_pkg::*;

    item_t   item;
    cmd_t    cmd;
    status_t sts;
    result_t res;
    logic    idle;
    logic    ovalid_reg;

    assign item.opcode       = s_axis_tdata[1:0];
    assign item.char_byte    = s_axis_tdata[9:2];
    assign item.is_multibyte = s_axis_tdata[10];
    assign item.table_index  = s_axis_tdata[18:11];
    assign item.range_lower  = s_axis_tdata[26:19];
    assign item.range_upper  = s_axis_tdata[34:27];
    assign item.target_state = s_axis_tdata[40:35];
    assign item.action_code  = s_axis_tdata[46:41];
    assign item.keep_state   = s_axis_tdata[47];
    assign item.pre_base     = s_axis_tdata[55:48];
    assign item.main_base    = s_axis_tdata[63:56];
    assign item.state_flags  = s_axis_tdata[65:64];

    assign s_axis_tready = idle && !ovalid_reg;

    estp_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_fire(s_axis_tvalid && s_axis_tready),
        .out_busy(ovalid_reg), .sts(sts), .idle(idle), .cmd(cmd)
    );

    estp_datapath #(
        .ENTRIES(ENTRIES), .STATES(STATES),
        .NUM_PARAMS(NUM_PARAMS), .MAX_WALK(MAX_WALK)
    ) u_dp (
        .clk(clk), .rst_n(rst_n), .item(item), .cmd(cmd), .sts(sts), .res(res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            ovalid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            ovalid_reg <= 1'b0;
        end
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata = {5'b0, res.read_value, res.sign_code,
                           res.number_is_default, res.working_number,
                           res.no_match, res.matched_pre, res.action_taken,
                           res.action_out, res.not_at_start};

endmodule

FILE: rtl/estp_checker.sv
module estp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [79:0] m_axis_tdata
);

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input taken while a result waits");

    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid && !s_axis_tready)
        else $error("word accepted while another is in flight");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[9] && (m_axis_tdata[8] || m_axis_tdata[7])))
        else $error("miss reported together with a match");

endmodule

bind escape_sequence_table_parser_unit estp_checker u_estp_checker (
    .clk(clk), .rst_n(rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);

FILE: sim/tb_escape_sequence_table_parser_unit.sv
`timescale 1ns / 100ps

module tb_escape_sequence_table_parser_unit;
    import estp_pkg::*;

    localparam int N_ENTRIES = 256;
    localparam int N_STATES = 64;
    localparam int N_SLOTS = 16;
    localparam int WALK_LEN = 64;
    localparam int CYCLE_LIMIT = 4000000;

    typedef struct {
        item_t it;
        bit    drain;
    } pending_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [79:0] m_axis_tdata;

    pending_t pending_words[$];
    result_t  expected_results[$];
    item_t    word_in_flight;
    int       fail_count = 0;
    int       cycle_count = 0;

    logic [7:0]  ent_lo [N_ENTRIES];
    logic [7:0]  ent_hi [N_ENTRIES];
    logic [5:0]  ent_tgt [N_ENTRIES];
    logic        ent_keep [N_ENTRIES];
    logic [5:0]  ent_act [N_ENTRIES];
    logic [7:0]  desc_pre [N_STATES];
    logic [7:0]  desc_main [N_STATES];
    logic [1:0]  desc_flags [N_STATES];
    logic [5:0]  cur_state = '0;
    logic [30:0] number_acc = '0;
    logic        number_default = 1'b1;
    logic [1:0]  sign_reg = SIGN_NONE;
    logic [30:0] slots [N_SLOTS];

    logic [7:0] k_list [4] = '{8'd0, 8'd15, 8'd16, 8'd255};
    logic [7:0] byte_list [6] = '{8'h41, 8'h00, 8'hff, 8'h2d, 8'h30, 8'h39};

    escape_sequence_table_parser_unit u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always #5 clk = ~clk;

    function automatic logic [71:0] pack_word(item_t it);
        return {6'd0, it.state_flags, it.main_base, it.pre_base, it.keep_state,
                it.action_code, it.target_state, it.range_upper, it.range_lower,
                it.table_index, it.is_multibyte, it.char_byte, it.opcode};
    endfunction

    function automatic result_t unpack_result(logic [79:0] d);
        result_t r;
        r.not_at_start = d[0];
        r.action_out = d[6:1];
        r.action_taken = d[7];
        r.matched_pre = d[8];
        r.no_match = d[9];
        r.working_number = d[40:10];
        r.number_is_default = d[41];
        r.sign_code = d[43:42];
        r.read_value = d[74:44];
        return r;
    endfunction

    function automatic bit is_full_range(logic [7:0] idx);
        return ent_lo[idx] == 8'h00 && ent_hi[idx] == 8'hff;
    endfunction

    function automatic bit scan_list(logic [7:0] base, logic [7:0] ch, bit multi,
                                     output logic [7:0] hit);
        logic [7:0] idx;
        idx = base;
        hit = '0;
        for (int i = 0; i < WALK_LEN; i++)
        begin
            if (multi ? is_full_range(idx) : (ch >= ent_lo[idx] && ch <= ent_hi[idx]))
            begin
                hit = idx;
                return 1'b1;
            end
            idx = idx + 8'd1;
        end
        return 1'b0;
    endfunction

    function automatic void apply_action(logic [5:0] act, logic [7:0] ch);
        logic [31:0] grown;
        if (act == ACT_CLEAR)
        begin
            for (int i = 0; i < N_SLOTS; i++)
                slots[i] = '0;
            number_acc = '0;
            number_default = 1'b1;
            sign_reg = SIGN_NONE;
        end
        else if (act == ACT_DIGIT)
        begin
            if (number_acc < DIGIT_LIMIT)
            begin
                grown = 32'(number_acc) * 32'd10 + 32'(ch) - 32'(CHAR_ZERO);
                number_acc = grown[30:0];
            end
            number_default = 1'b0;
        end
        else if (act == ACT_SIGN)
            sign_reg = (ch == CHAR_MINUS) ? SIGN_NEG : SIGN_POS;
        else if (act >= ACT_PUSH_FIRST && act <= ACT_PUSH_LAST)
        begin
            slots[act - ACT_PUSH_FIRST] = number_acc;
            number_acc = '0;
            number_default = 1'b0;
        end
    endfunction

    function automatic result_t parse_and_predict(item_t it);
        result_t r;
        logic [7:0] hit;
        bit found;
        r = '0;
        found = 1'b0;
        case (it.opcode)
            OP_WR_ENTRY:
            begin
                ent_lo[it.table_index] = it.range_lower;
                ent_hi[it.table_index] = it.range_upper;
                ent_tgt[it.table_index] = it.target_state;
                ent_act[it.table_index] = it.action_code;
                ent_keep[it.table_index] = it.keep_state;
            end
            OP_WR_STATE:
            begin
                if (it.table_index < N_STATES)
                begin
                    desc_pre[it.table_index] = it.pre_base;
                    desc_main[it.table_index] = it.main_base;
                    desc_flags[it.table_index] = it.state_flags;
                end
            end
            OP_READ:
            begin
                if (it.table_index < N_SLOTS)
                    r.read_value = slots[it.table_index];
            end
            default:
            begin
                if (desc_flags[cur_state][0] && !it.is_multibyte)
                begin
                    if (scan_list(desc_pre[cur_state], it.char_byte, 1'b0, hit)
                        && !is_full_range(hit))
                    begin
                        found = 1'b1;
                        r.matched_pre = 1'b1;
                        if (!ent_keep[hit])
                            cur_state = ent_tgt[hit];
                    end
                end
                if (!found)
                begin
                    if (scan_list(desc_main[cur_state], it.char_byte, it.is_multibyte, hit))
                    begin
                        found = 1'b1;
                        cur_state = ent_tgt[hit];
                    end
                    else
                        r.no_match = 1'b1;
                end
                if (found)
                begin
                    r.action_out = ent_act[hit];
                    r.action_taken = ent_act[hit] != ACT_NONE;
                    apply_action(ent_act[hit], it.char_byte);
                end
            end
        endcase
        r.not_at_start = !desc_flags[cur_state][1];
        r.working_number = number_acc;
        r.number_is_default = number_default;
        r.sign_code = sign_reg;
        return r;
    endfunction

    function automatic logic [5:0] pick_action();
        int unsigned k;
        k = $urandom_range(0, 19);
        if (k < 3)
            return ACT_NONE;
        else if (k < 5)
            return ACT_CLEAR;
        else if (k < 10)
            return ACT_DIGIT;
        else if (k < 12)
            return ACT_SIGN;
        else if (k < 17)
            return 6'($urandom_range(ACT_PUSH_FIRST, ACT_PUSH_LAST));
        return 6'($urandom_range(20, 63));
    endfunction

    function automatic item_t noise_word(logic [1:0] op);
        item_t it;
        it = item_t'({$urandom, $urandom, $urandom});
        it.opcode = op;
        return it;
    endfunction

    function automatic item_t entry_word(logic [7:0] idx);
        item_t it;
        int unsigned k;
        it = noise_word(OP_WR_ENTRY);
        it.table_index = idx;
        it.action_code = pick_action();
        k = $urandom_range(0, 9);
        if (k == 0)
        begin
            it.range_lower = 8'h00;
            it.range_upper = 8'hff;
        end
        else if (k < 4)
        begin
            it.range_lower = CHAR_ZERO;
            it.range_upper = CHAR_ZERO + 8'd9;
            if (k == 1)
                it.action_code = ACT_DIGIT;
        end
        else if (k == 4)
        begin
            it.range_lower = CHAR_MINUS;
            it.range_upper = CHAR_MINUS;
        end
        else if (k < 9)
        begin
            it.range_upper = it.range_lower + 8'($urandom_range(0, 15));
            if (it.range_upper < it.range_lower)
                it.range_upper = 8'hff;
        end
        return it;
    endfunction

    function automatic item_t state_word(logic [7:0] idx);
        item_t it;
        it = noise_word(OP_WR_STATE);
        it.table_index = idx;
        return it;
    endfunction

    function automatic item_t parse_word();
        item_t it;
        int unsigned k;
        it = noise_word(OP_PARSE);
        k = $urandom_range(0, 9);
        if (k < 4)
            it.char_byte = CHAR_ZERO + 8'($urandom_range(0, 9));
        else if (k == 4)
            it.char_byte = CHAR_MINUS;
        it.is_multibyte = $urandom_range(0, 9) == 0;
        return it;
    endfunction

    task automatic queue_word(item_t it, bit drain = 1'b0);
        pending_t p;
        p.it = it;
        p.drain = drain;
        pending_words.push_back(p);
    endtask

    task automatic check_field(string name, logic [30:0] exp_v, logic [30:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // Sender: bursts and gaps, with an occasional wait until every result is back.
    int burst_left = 0;
    int gap_left = 0;
    bit waiting_empty = 1'b0;

    always @(posedge clk or negedge rst_n)
    begin
        logic next_valid;
        pending_t p;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
        end
        else
        begin
            next_valid = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_results.push_back(parse_and_predict(word_in_flight));
                next_valid = 1'b0;
            end
            if (!next_valid)
            begin
                if (waiting_empty && expected_results.size() == 0)
                    waiting_empty = 1'b0;
                if (gap_left > 0)
                    gap_left--;
                else if (!waiting_empty && pending_words.size() > 0)
                begin
                    p = pending_words.pop_front();
                    word_in_flight = p.it;
                    s_axis_tdata <= pack_word(p.it);
                    next_valid = 1'b1;
                    waiting_empty = p.drain;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(0, 30);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
            end
            s_axis_tvalid <= next_valid;
        end
    end

    // Receiver: stall pattern of its own plus rare long hold-offs.
    int hold_left = 0;
    int phase_left = 0;
    bit phase_ready = 1'b1;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (cycle_count == 5000 || $urandom_range(0, 9999) == 0)
            begin
                hold_left = 400;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                if (phase_left == 0)
                begin
                    phase_ready = ($urandom_range(0, 3) != 0);
                    phase_left = phase_ready ? $urandom_range(1, 60) : $urandom_range(1, 8);
                end
                else
                    phase_left--;
                m_axis_tready <= phase_ready || $urandom_range(0, 1);
            end
        end
    end

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = unpack_result(m_axis_tdata);
            if (expected_results.size() == 0)
            begin
                $error("Result word with no expectation waiting");
                fail_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("not_at_start", 31'(want.not_at_start), 31'(got.not_at_start));
                check_field("action_out", 31'(want.action_out), 31'(got.action_out));
                check_field("action_taken", 31'(want.action_taken), 31'(got.action_taken));
                check_field("matched_pre", 31'(want.matched_pre), 31'(got.matched_pre));
                check_field("no_match", 31'(want.no_match), 31'(got.no_match));
                check_field("working_number", want.working_number, got.working_number);
                check_field("number_is_default", 31'(want.number_is_default),
                            31'(got.number_is_default));
                check_field("sign_code", 31'(want.sign_code), 31'(got.sign_code));
                check_field("read_value", want.read_value, got.read_value);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        item_t it;
        int unsigned k;
        for (int i = 0; i < N_SLOTS; i++)
            slots[i] = '0;

        // Load every entry and descriptor so that no walk touches unwritten memory.
        for (int i = 0; i < N_ENTRIES; i++)
            queue_word(entry_word(8'(i)));
        for (int i = 0; i < N_STATES; i++)
            queue_word(state_word(8'(i)));

        it = entry_word(8'hff);
        it.range_lower = 8'hff;
        it.range_upper = 8'hff;
        it.target_state = 6'd63;
        it.action_code = 6'd63;
        it.keep_state = 1'b1;
        queue_word(it);
        it = entry_word(8'h00);
        it.range_lower = 8'h00;
        it.range_upper = 8'hff;
        it.target_state = 6'd0;
        it.action_code = ACT_CLEAR;
        it.keep_state = 1'b0;
        queue_word(it);
        it = state_word(8'd63);
        it.pre_base = 8'hff;
        it.main_base = 8'hff;
        it.state_flags = 2'd3;
        queue_word(it);
        queue_word(state_word(8'd200));
        queue_word(state_word(8'hff));
        foreach (k_list[i])
        begin
            it = noise_word(OP_READ);
            it.table_index = k_list[i];
            queue_word(it);
        end
        foreach (byte_list[i])
        begin
            it = parse_word();
            it.char_byte = byte_list[i];
            it.is_multibyte = (i == 0);
            queue_word(it);
        end

        for (int n = 0; n < 2000; n++)
        begin
            k = $urandom_range(0, 99);
            if (k < 85)
                it = parse_word();
            else if (k < 92)
                it = entry_word(8'($urandom));
            else if (k < 95)
                it = state_word(8'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 63)));
            else
            begin
                it = noise_word(OP_READ);
                if ($urandom_range(0, 3) != 0)
                    it.table_index = 8'($urandom_range(0, 31));
            end
            queue_word(it, n == 700 || n == 1500);
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(posedge clk);
        while (pending_words.size() > 0 || s_axis_tvalid);
        while (expected_results.size() > 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
